// ===== rtl/awur_pkg.sv =====
package awur_pkg;

  typedef enum logic [2:0] {
    FN_CLEAR = 3'd0,
    FN_UNDO  = 3'd1,
    FN_REDO  = 3'd2,
    FN_ADD   = 3'd3,
    FN_SUB   = 3'd4,
    FN_MUL   = 3'd5,
    FN_DIV   = 3'd6,
    FN_MOD   = 3'd7
  } func_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_REDO = 3'd1;
  localparam logic [2:0] ST_NO_UNDO = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture the input item
    logic div_start;    // start the iterative divider
    logic div_step;     // one divider iteration
    logic hist_rd;      // read history at count-2 (undo)
    logic redo_rd;      // read redo top
    logic commit;       // apply the decided update
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_div;       // accepted op needs the divider
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/awur_ctrl.sv =====
module awur_ctrl
  import awur_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        cmd.hist_rd = 1'b1;
        cmd.redo_rd = 1'b1;
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_RD;
      end
      S_RD: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit not followed by result");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready during pending result");

endmodule

// ===== rtl/awur_dp.sv =====
module awur_dp
  import awur_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256
)
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  output out_item_t out_item,
  input  cmd_t      cmd,
  output stat_t     stat
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

  logic [31:0] hist_mem [HISTORY_DEPTH];
  logic [31:0] redo_mem [HISTORY_DEPTH];

  logic [2:0]    func;
  logic [31:0]   opnd;
  logic [31:0]   cur;
  logic [CW-1:0] hcnt;
  logic [CW-1:0] rcnt;
  logic [31:0]   hist_q;
  logic [31:0]   redo_q;
  logic [2:0]    status;

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func <= in_item.func;
      opnd <= in_item.operand;
    end
  end

  // Decide status from the counts and the operand.
  logic [2:0] st_dec;
  logic full_h;
  assign full_h = (hcnt >= DEPTH_C);
  always_comb begin
    st_dec = ST_OK;
    case (func)
      FN_CLEAR: if (full_h) st_dec = ST_FULL;
      FN_UNDO: begin
        if (hcnt <= CW'(1)) st_dec = ST_NO_UNDO;
        else if (rcnt >= DEPTH_C) st_dec = ST_FULL;
      end
      FN_REDO: begin
        if (rcnt == '0) st_dec = ST_NO_REDO;
        else if (full_h) st_dec = ST_FULL;
      end
      default: begin
        if (opnd == '0) st_dec = ST_ZERO;
        else if (full_h) st_dec = ST_FULL;
      end
    endcase
  end

  assign stat.is_div = (func == FN_DIV || func == FN_MOD) && (st_dec == ST_OK);

  // Registered memory reads; addresses are valid when the read is used.
  logic [CW-1:0] h_rd_c, r_rd_c;
  assign h_rd_c = hcnt - CW'(2);
  assign r_rd_c = rcnt - CW'(1);
  always_ff @(posedge clk) begin
    if (cmd.hist_rd) hist_q <= hist_mem[h_rd_c[AW-1:0]];
    if (cmd.redo_rd) redo_q <= redo_mem[r_rd_c[AW-1:0]];
  end

  // Iterative restoring divider on magnitudes, one quotient bit a cycle.
  logic [31:0] dq, dd, ma, mb;
  logic [32:0] rem, trial;
  logic [5:0]  dcnt;
  logic        neg_q, neg_r;
  assign ma = cur[31] ? (32'd0 - cur) : cur;
  assign mb = opnd[31] ? (32'd0 - opnd) : opnd;
  assign trial = {rem[31:0], dq[31]} - {1'b0, dd};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= ma;
      dd <= mb;
      rem <= '0;
      dcnt <= 6'd32;
      neg_q <= cur[31] ^ opnd[31];
      neg_r <= cur[31];
    end else if (cmd.div_step && dcnt != '0) begin
      if (!trial[32]) begin
        rem <= trial;
        dq <= {dq[30:0], 1'b1};
      end else begin
        rem <= {rem[31:0], dq[31]};
        dq <= {dq[30:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
  end
  assign stat.div_done = (dcnt == 6'd1);

  // Result of the arithmetic operation.
  logic [31:0] ar;
  always_comb begin
    case (func)
      FN_ADD: ar = cur + opnd;
      FN_SUB: ar = cur - opnd;
      FN_MUL: ar = cur * opnd;
      FN_DIV: ar = neg_q ? (32'd0 - dq) : dq;
      FN_MOD: ar = neg_r ? (32'd0 - rem[31:0]) : rem[31:0];
      default: ar = '0;
    endcase
  end

  // Commit state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= CW'(1);
      rcnt <= '0;
      cur <= '0;
      status <= ST_OK;
    end else if (cmd.commit) begin
      status <= st_dec;
      if (st_dec == ST_OK) begin
        case (func)
          FN_CLEAR: begin
            cur <= '0;
            hcnt <= hcnt + CW'(1);
          end
          FN_UNDO: begin
            cur <= hist_q;
            hcnt <= hcnt - CW'(1);
            rcnt <= rcnt + CW'(1);
          end
          FN_REDO: begin
            cur <= redo_q;
            hcnt <= hcnt + CW'(1);
            rcnt <= rcnt - CW'(1);
          end
          default: begin
            cur <= ar;
            hcnt <= hcnt + CW'(1);
            rcnt <= '0;
          end
        endcase
      end
    end
  end

  // Memory writes at commit; reset writes the zero root entry to hist_mem[0].
  always_ff @(posedge clk) begin
    if (cmd.commit && st_dec == ST_OK) begin
      case (func)
        FN_CLEAR: hist_mem[hcnt[AW-1:0]] <= '0;
        FN_UNDO:  redo_mem[rcnt[AW-1:0]] <= cur;
        FN_REDO:  hist_mem[hcnt[AW-1:0]] <= redo_q;
        default:  hist_mem[hcnt[AW-1:0]] <= ar;
      endcase
    end
    if (rst) hist_mem[0] <= '0;
  end

  assign out_item.value  = cur;
  assign out_item.status = status;

  a_hcnt: assert property (@(posedge clk) disable iff (rst)
    hcnt >= CW'(1) && hcnt <= DEPTH_C)
    else $error("history count out of range");
  a_rcnt: assert property (@(posedge clk) disable iff (rst) rcnt <= DEPTH_C)
    else $error("redo count out of range");
  a_reject: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && st_dec != ST_OK |=> $stable(hcnt) && $stable(cur))
    else $error("rejected item changed state");

endmodule

// ===== rtl/accumulator_with_undo_redo.sv =====
// Sequence: a taken item passes S_DEC, then S_RD (commit), and the result is offered
// in S_OUT; divide and modulo pass S_DIV between S_DEC and S_RD (32-step divider).
// One item at a time: the next item is taken only after the result leaves.
// Reset (rst, synchronous): history holds only the zero root, redo empty,
// value zero.
module accumulator_with_undo_redo
  import awur_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  awur_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  awur_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .in_item(in_data), .out_item(out_data),
    .cmd(cmd), .stat(stat)
  );

endmodule
